FILE: rtl/core/rtfm_pkg.sv
// Shared types, constants and a helper function for the first-match route table.
package rtfm_pkg;

    localparam int UC_ENTRIES = 16;
    localparam int MC_ENTRIES = 16;
    localparam int MAX_PORTS  = 16;
    localparam int UC_IDX_W   = $clog2(UC_ENTRIES);
    localparam int MC_IDX_W   = $clog2(MC_ENTRIES);
    localparam int SCAN_W     = (UC_IDX_W > MC_IDX_W) ? UC_IDX_W : MC_IDX_W;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_DELETE = 3'd2;
    localparam logic [2:0] OP_COUNT  = 3'd3;
    localparam logic [2:0] OP_NTH    = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_BAD_IF    = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] address;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic [15:0] route_metric;
        logic        port_given;
        logic [3:0]  port_number;
        logic [3:0]  nth;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  out_port;
        logic [31:0] next_hop;
        logic [4:0]  match_count;
        logic        deleted;
    } t_rsp;

    // Controller -> datapath
    typedef struct packed {
        logic             load;       // capture request
        logic             clear;      // clear scan bookkeeping
        logic             scan_uc;    // examine unicast slot at idx
        logic             scan_mc;    // examine multicast slot at idx
        logic             gw_key;     // unicast scan keys on gateway
        logic [SCAN_W-1:0] idx;
        logic             finish;     // form the result
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic [2:0] operation;
    } t_sts;

    function automatic logic [31:0] classful_mask(input logic [31:0] a);
        logic [31:0] m;
        if (!a[31])            m = 32'hFF00_0000;
        else if (!a[30])       m = 32'hFFFF_0000;
        else if (!a[29])       m = 32'hFFFF_FF00;
        else                   m = 32'h0000_0000;
        return m;
    endfunction

endpackage

FILE: rtl/core/rtfm_datapath.sv
// Route table storage, per-slot match logic and result formation.
module rtfm_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [4:0]      i_if_count,
    input  rtfm_pkg::t_req  i_req,
    input  rtfm_pkg::t_cmd  i_cmd,
    output rtfm_pkg::t_sts  o_sts,
    output rtfm_pkg::t_rsp  o_rsp
);
    import rtfm_pkg::*;

    logic [UC_ENTRIES-1:0] r_uc_valid;
    logic [31:0] r_uc_dest [UC_ENTRIES];
    logic [31:0] r_uc_mask [UC_ENTRIES];
    logic [31:0] r_uc_gw   [UC_ENTRIES];
    logic [15:0] r_uc_met  [UC_ENTRIES];
    logic [3:0]  r_uc_port [UC_ENTRIES];
    logic [MC_ENTRIES-1:0] r_mc_valid;
    logic [31:0] r_mc_dest [MC_ENTRIES];
    logic [31:0] r_mc_mask [MC_ENTRIES];
    logic [31:0] r_mc_gw   [MC_ENTRIES];
    logic [15:0] r_mc_met  [MC_ENTRIES];
    logic [3:0]  r_mc_port [MC_ENTRIES];
    logic        r_df_valid;
    logic [31:0] r_df_mask;
    logic [31:0] r_df_gw;
    logic [15:0] r_df_met;
    logic [3:0]  r_df_port;

    t_req r_req;
    logic        r_uc_found;   // first unicast match seen
    logic [3:0]  r_uc_hit_port;
    logic [31:0] r_uc_hit_gw;
    logic        r_uc_free_ok;
    logic [UC_IDX_W-1:0] r_uc_free;
    logic        r_mc_free_ok;
    logic [MC_IDX_W-1:0] r_mc_free;
    logic [4:0]  r_mcount;
    logic [3:0]  r_seen;
    logic        r_nth_found;
    logic [3:0]  r_nth_port;
    logic [31:0] r_nth_gw;
    logic        r_deleted;
    t_rsp        r_rsp;

    logic [UC_IDX_W-1:0] uc_i;
    logic [MC_IDX_W-1:0] mc_i;
    logic [31:0] key;
    logic        uc_hit, mc_hit, uc_del, mc_del, df_del;
    logic [31:0] add_mask;

    assign uc_i = i_cmd.idx[UC_IDX_W-1:0];
    assign mc_i = i_cmd.idx[MC_IDX_W-1:0];
    assign key  = i_cmd.gw_key ? r_req.gateway : r_req.address;
    assign add_mask = (r_req.netmask != 32'd0) ? r_req.netmask : classful_mask(r_req.address);

    function automatic logic crit(input t_req q, input logic [31:0] m, input logic [31:0] g,
                                  input logic [15:0] me, input logic [3:0] p);
        return (q.netmask == 32'd0 || q.netmask == m) && (q.gateway == 32'd0 || q.gateway == g)
            && (q.route_metric == 16'd0 || q.route_metric == me)
            && (!q.port_given || q.port_number == p);
    endfunction

    assign uc_hit = r_uc_valid[uc_i] && ((key & r_uc_mask[uc_i]) == (r_uc_dest[uc_i] & r_uc_mask[uc_i]));
    assign mc_hit = r_mc_valid[mc_i] &&
        ((r_req.address & r_mc_mask[mc_i]) == (r_mc_dest[mc_i] & r_mc_mask[mc_i]));
    assign uc_del = r_uc_valid[uc_i] && r_req.address != 32'd0 && r_uc_dest[uc_i] == r_req.address
        && crit(r_req, r_uc_mask[uc_i], r_uc_gw[uc_i], r_uc_met[uc_i], r_uc_port[uc_i]);
    assign mc_del = r_mc_valid[mc_i] && r_req.address != 32'd0 && r_mc_dest[mc_i] == r_req.address
        && crit(r_req, r_mc_mask[mc_i], r_mc_gw[mc_i], r_mc_met[mc_i], r_mc_port[mc_i]);
    assign df_del = r_df_valid && r_req.address == 32'd0
        && crit(r_req, r_df_mask, r_df_gw, r_df_met, r_df_port);

    // Result formation and the single table write of an add
    t_rsp        n_rsp;
    logic        wr_uc, wr_mc, wr_df;
    logic [3:0]  add_port;
    logic        add_ok;
    always_comb begin
        n_rsp = '0;
        wr_uc = 1'b0;
        wr_mc = 1'b0;
        wr_df = 1'b0;
        add_port = r_req.port_given ? r_req.port_number : (r_uc_found ? r_uc_hit_port : r_df_port);
        add_ok = r_req.port_given ? ({1'b0, r_req.port_number} < i_if_count)
                                  : (r_req.gateway != 32'd0 && (r_uc_found || r_df_valid));
        case (r_req.operation)
            OP_LOOKUP: begin
                if (r_uc_found) begin
                    n_rsp.out_port = r_uc_hit_port;
                    n_rsp.next_hop = r_uc_hit_gw;
                end else if (r_df_valid) begin
                    n_rsp.out_port = r_df_port;
                    n_rsp.next_hop = r_df_gw;
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            OP_ADD: begin
                if (!add_ok) begin
                    n_rsp.status = ST_BAD_IF;
                end else if (r_req.address == 32'd0) begin
                    wr_df = 1'b1;
                end else if (r_req.address[31:28] == 4'hE) begin
                    wr_mc = r_mc_free_ok;
                end else begin
                    wr_uc = r_uc_free_ok;
                end
                if (add_ok && !wr_df && !wr_mc && !wr_uc) begin
                    n_rsp.status = ST_FULL;
                end
                if (wr_df || wr_mc || wr_uc) begin
                    n_rsp.out_port = add_port;
                    n_rsp.next_hop = r_req.gateway;
                end
            end
            OP_DELETE: begin
                n_rsp.deleted = r_deleted;
                n_rsp.status  = r_deleted ? ST_OK : ST_NOT_FOUND;
            end
            OP_COUNT: begin
                n_rsp.match_count = r_mcount;
            end
            OP_NTH: begin
                if (r_nth_found) begin
                    n_rsp.out_port = r_nth_port;
                    n_rsp.next_hop = r_nth_gw;
                end else begin
                    n_rsp.status = ST_BAD_INDEX;
                end
            end
            default: n_rsp.status = ST_BAD_INDEX;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uc_valid <= '0;
            r_mc_valid <= '0;
            r_df_valid <= 1'b0;
            r_df_mask  <= '0;
            r_df_gw    <= '0;
            r_df_met   <= '0;
            r_df_port  <= '0;
        end else begin
            if (i_cmd.scan_uc && r_req.operation == OP_DELETE && uc_del) begin
                r_uc_valid[uc_i] <= 1'b0;
            end
            if (i_cmd.scan_mc && r_req.operation == OP_DELETE && mc_del) begin
                r_mc_valid[mc_i] <= 1'b0;
            end
            if (i_cmd.clear && r_req.operation == OP_DELETE && df_del) begin
                r_df_valid <= 1'b0;
            end
            if (i_cmd.finish && wr_uc) begin
                r_uc_valid[r_uc_free] <= 1'b1;
            end
            if (i_cmd.finish && wr_mc) begin
                r_mc_valid[r_mc_free] <= 1'b1;
            end
            if (i_cmd.finish && wr_df) begin
                r_df_valid <= 1'b1;
                r_df_mask  <= add_mask;
                r_df_gw    <= r_req.gateway;
                r_df_met   <= r_req.route_metric;
                r_df_port  <= add_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && wr_uc) begin
            r_uc_dest[r_uc_free] <= r_req.address;
            r_uc_mask[r_uc_free] <= add_mask;
            r_uc_gw[r_uc_free]   <= r_req.gateway;
            r_uc_met[r_uc_free]  <= r_req.route_metric;
            r_uc_port[r_uc_free] <= add_port;
        end
        if (i_cmd.finish && wr_mc) begin
            r_mc_dest[r_mc_free] <= r_req.address;
            r_mc_mask[r_mc_free] <= add_mask;
            r_mc_gw[r_mc_free]   <= r_req.gateway;
            r_mc_met[r_mc_free]  <= r_req.route_metric;
            r_mc_port[r_mc_free] <= add_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.clear) begin
            r_uc_found   <= 1'b0;
            r_uc_free_ok <= 1'b0;
            r_mc_free_ok <= 1'b0;
            r_mcount     <= '0;
            r_seen       <= '0;
            r_nth_found  <= 1'b0;
            r_deleted    <= (r_req.operation == OP_DELETE) && df_del;
        end
        if (i_cmd.scan_uc) begin
            if (uc_hit && !r_uc_found) begin
                r_uc_found    <= 1'b1;
                r_uc_hit_port <= r_uc_port[uc_i];
                r_uc_hit_gw   <= r_uc_gw[uc_i];
            end
            if (!r_uc_valid[uc_i] && !r_uc_free_ok) begin
                r_uc_free_ok <= 1'b1;
                r_uc_free    <= uc_i;
            end
            if (r_req.operation == OP_DELETE && uc_del) begin
                r_deleted <= 1'b1;
            end
        end
        if (i_cmd.scan_mc) begin
            if (mc_hit && r_mcount != 5'd31) begin
                r_mcount <= r_mcount + 5'd1;
            end
            if (mc_hit && !r_nth_found) begin
                if (r_seen == r_req.nth) begin
                    r_nth_found <= 1'b1;
                    r_nth_port  <= r_mc_port[mc_i];
                    r_nth_gw    <= r_mc_gw[mc_i];
                end
                r_seen <= r_seen + 4'd1;
            end
            if (!r_mc_valid[mc_i] && !r_mc_free_ok) begin
                r_mc_free_ok <= 1'b1;
                r_mc_free    <= mc_i;
            end
            if (r_req.operation == OP_DELETE && mc_del) begin
                r_deleted <= 1'b1;
            end
        end
        if (i_cmd.finish) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.operation = r_req.operation;
    assign o_rsp = r_rsp;
endmodule

FILE: rtl/core/rtfm_ctrl.sv
// Sequencer: accepts a transaction, scans both tables slot by slot, hands off the result.
module rtfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rtfm_pkg::t_sts i_sts,
    output rtfm_pkg::t_cmd o_cmd
);
    import rtfm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_UC   = 3'd2;
    localparam logic [2:0] S_MC   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [SCAN_W-1:0] r_idx, n_idx;
    logic              gw_key;

    // An add keys the unicast scan on the gateway
    assign gw_key = (i_sts.operation == OP_ADD);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_cmd.idx    = r_idx;
        o_cmd.gw_key = gw_key;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.clear = 1'b1;
                n_idx   = '0;
                n_state = S_UC;
            end
            S_UC: begin
                o_cmd.scan_uc = 1'b1;
                if (r_idx == SCAN_W'(UC_ENTRIES - 1)) begin
                    n_idx   = '0;
                    n_state = S_MC;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_MC: begin
                o_cmd.scan_mc = 1'b1;
                if (r_idx == SCAN_W'(MC_ENTRIES - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end
endmodule

FILE: rtl/core/ipv4_route_table_first_match.sv
// Top level of the IPv4 first-match route table.
//   channel  | direction | handshake                      | payload
//   in       | input     | i_in_valid / o_in_ready        | operation .. nth
//   out      | output    | o_out_valid / i_out_ready      | status .. deleted
//   cfg      | input     | i_cfg_valid / o_cfg_ready      | interface_count
// Each transaction runs a setup step, a scan of the unicast slots, a scan of the multicast
// slots and a result step before the result is valid, one table slot per cycle.
// A new transaction is taken only once the result has been handed off, so transactions
// never overlap; a stalled result holds off the input.
// Synchronous active-low reset empties both tables and the default route.
module ipv4_route_table_first_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_address,
    input  logic [31:0] i_netmask,
    input  logic [31:0] i_gateway,
    input  logic [15:0] i_route_metric,
    input  logic        i_port_given,
    input  logic [3:0]  i_port_number,
    input  logic [3:0]  i_nth,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_out_port,
    output logic [31:0] o_next_hop,
    output logic [4:0]  o_match_count,
    output logic        o_deleted
);
    import rtfm_pkg::*;

    logic [4:0] r_if_count;
    t_req req;
    t_cmd cmd;
    t_sts sts;
    t_rsp rsp;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_count <= 5'd16;
        end else if (i_cfg_valid) begin
            r_if_count <= i_cfg_data;
        end
    end

    assign req = '{operation: i_operation, address: i_address, netmask: i_netmask,
                   gateway: i_gateway, route_metric: i_route_metric,
                   port_given: i_port_given, port_number: i_port_number, nth: i_nth};

    rtfm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd)
    );

    rtfm_datapath u_dp (
        .i_clk, .i_rst_n, .i_if_count(r_if_count), .i_req(req), .i_cmd(cmd),
        .o_sts(sts), .o_rsp(rsp)
    );

    assign o_status      = rsp.status;
    assign o_out_port    = rsp.out_port;
    assign o_next_hop    = rsp.next_hop;
    assign o_match_count = rsp.match_count;
    assign o_deleted     = rsp.deleted;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output open together");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> o_in_ready) else $error("load outside idle");
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> o_out_valid) else $error("result not presented");
    a_del_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_deleted |-> o_status == ST_OK) else $error("deleted with bad status");
endmodule
